### sv/tess_pkg.sv
// ----------------------------------------------------------------------------
// tess_pkg: shared types and constants for the truss element stiffness scatter
// Pipeline stage numbering, fixed widths, saturation limits and the record
// that travels down the element pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tess_pkg;

	// Global dof count; an index at or above it marks the dof as constrained
	localparam int MAX_DOFS      = 4096;
	localparam int DOFS_PER_NODE = 3;
	localparam int LOCAL_DOFS    = 2 * DOFS_PER_NODE;
	// Distinct cosine products (symmetric 3x3)
	localparam int NPAIR         = 6;

	localparam int IDX_W  = 12;
	localparam int DLT_W  = 32;
	localparam int VAL_W  = 48;
	localparam int IN_W   = 208;
	localparam int OUT_W  = 72;

	// Stage map of the element pipeline
	localparam int ST_SQR   = 1;
	localparam int ST_SUM   = 2;
	localparam int ST_RT0   = 3;
	localparam int RT_STEPS = 32;
	localparam int ST_CS0   = ST_RT0 + RT_STEPS;
	localparam int CS_STEPS = 31;
	localparam int ST_CC    = ST_CS0 + CS_STEPS;
	localparam int ST_PRD   = ST_CC + 1;
	localparam int ST_DV0   = ST_PRD + 1;
	localparam int DV_STEPS = 48;
	localparam int NST      = ST_DV0 + DV_STEPS;

	// Cosine index pairs of the distinct products, lowest entry first
	localparam logic [NPAIR-1:0][1:0] PAIR_A = {2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0};
	localparam logic [NPAIR-1:0][1:0] PAIR_B = {2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd0};

	localparam logic [VAL_W-1:0] POS_LIM = 48'h7FFF_FFFF_FFFF;
	localparam logic [VAL_W-1:0] NEG_LIM = 48'h8000_0000_0000;

	typedef struct packed {
		logic [2:0]                   sgn;
		logic [2:0][31:0]             dm;
		logic [31:0]                  ea;
		logic [LOCAL_DOFS-1:0][11:0]  idx;
		logic [LOCAL_DOFS-1:0]        act;
		logic                         zero;
		logic [2:0][63:0]             sq;
		logic [63:0]                  s;
		logic [34:0]                  srem;
		logic [31:0]                  root;
		logic [2:0][31:0]             crem;
		logic [2:0][30:0]             cq;
		logic [NPAIR-1:0][30:0]       cc;
		logic [NPAIR-1:0][31:0]       drem;
		logic [NPAIR-1:0][47:0]       dlow;
		logic [NPAIR-1:0][47:0]       dq;
		logic [NPAIR-1:0]             sat;
	} elem_t;

endpackage

`default_nettype wire

### sv/truss_element_stiffness_scatter_top.sv
// ----------------------------------------------------------------------------
// truss_element_stiffness_scatter_top: 3D truss element stiffness scatter
// Turns one two-node truss element into its free-dof stiffness contributions.
// ----------------------------------------------------------------------------
// An element beat enters a 116-stage pipeline (squares, sum, a 32-step square
// root, three 31-step cosine dividers, the cosine products, the EA products
// and six 48-step dividers) and then sits in an emit buffer that sends one
// contribution per cycle while the result side accepts, row-major over the
// free dofs. The pipeline takes a new element every cycle as long as the emit
// buffer keeps up; the buffer holds an element until it has sent all F*F
// contributions, F being the number of free dofs. A zero-length element sends
// a single beat and an element with no free dof sends none. Results pass from
// the last stage through the emit buffer and an output register. Back-pressure
// on the result side stalls the whole pipeline in place.
`default_nettype none

module truss_element_stiffness_scatter_top (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	// delta_x, delta_y, delta_z, axial_rigidity, first_x/y/z_index,
	// second_x/y/z_index, free_mask, 2 zero bits
	input  wire logic [tess_pkg::IN_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	// row_index, column_index, contribution
	output logic [tess_pkg::OUT_W-1:0]    m_tdata,
	// zero_length
	output logic                          m_tuser,
	// last_of_element
	output logic                          m_tlast
);
	import tess_pkg::*;

	// Unpack one input beat and take magnitudes and signs
	function automatic elem_t unpack(input logic [IN_W-1:0] d);
		elem_t r;
		logic [31:0] v;
		r = '0;
		for (int j = 0; j < 3; j++) begin
			v = d[j*DLT_W +: DLT_W];
			r.sgn[j] = v[31];
			r.dm[j]  = v[31] ? 32'd0 - v : v;
		end
		r.ea = d[3*DLT_W +: 32];
		for (int i = 0; i < LOCAL_DOFS; i++) begin
			r.idx[i] = d[4*DLT_W + i*IDX_W +: IDX_W];
			r.act[i] = d[4*DLT_W + LOCAL_DOFS*IDX_W + i] && (32'(r.idx[i]) < MAX_DOFS);
		end
		return r;
	endfunction

	// Work of pipeline stage k
	function automatic elem_t stage_fn(input int k, input elem_t e);
		elem_t       r;
		logic [34:0] rn;
		logic [34:0] tr;
		logic [32:0] c2;
		logic [32:0] df;
		logic [61:0] cp;
		logic [62:0] pm;
		r = e;
		if (k == ST_SQR) begin
			for (int j = 0; j < 3; j++) r.sq[j] = e.dm[j] * e.dm[j];
		end else if (k == ST_SUM) begin
			r.s    = e.sq[0] + e.sq[1] + e.sq[2];
			r.zero = (r.s == 64'd0);
			r.srem = '0;
			r.root = '0;
			for (int j = 0; j < 3; j++) begin
				r.crem[j] = {1'b0, e.dm[j][31:1]};
				r.cq[j]   = '0;
			end
		end else if (k >= ST_RT0 && k < ST_CS0) begin
			// one root digit per stage
			rn = {e.srem[32:0], e.s[63:62]};
			tr = {1'b0, e.root, 2'b01};
			if (rn >= tr) begin
				r.srem = rn - tr;
				r.root = {e.root[30:0], 1'b1};
			end else begin
				r.srem = rn;
				r.root = {e.root[30:0], 1'b0};
			end
			r.s = {e.s[61:0], 2'b00};
		end else if (k >= ST_CS0 && k < ST_CC) begin
			// one cosine quotient bit per stage
			for (int j = 0; j < 3; j++) begin
				c2 = {e.crem[j], (k == ST_CS0) ? e.dm[j][0] : 1'b0};
				df = c2 - {1'b0, e.root};
				if (c2 >= {1'b0, e.root}) begin
					r.crem[j] = df[31:0];
					r.cq[j]   = {e.cq[j][29:0], 1'b1};
				end else begin
					r.crem[j] = c2[31:0];
					r.cq[j]   = {e.cq[j][29:0], 1'b0};
				end
			end
		end else if (k == ST_CC) begin
			for (int p = 0; p < NPAIR; p++) begin
				cp = e.cq[PAIR_A[p]] * e.cq[PAIR_B[p]];
				r.cc[p] = cp[60:30];
			end
		end else if (k == ST_PRD) begin
			// dividend is 4*EA*cc, split into top 16 bits and a 48-bit tail
			for (int p = 0; p < NPAIR; p++) begin
				pm = e.ea * e.cc[p];
				r.drem[p] = {16'd0, pm[61:46]};
				r.dlow[p] = {pm[45:0], 2'b00};
				r.dq[p]   = '0;
				r.sat[p]  = 1'b0;
			end
		end else if (k >= ST_DV0 && k < NST) begin
			// one magnitude quotient bit per stage; flag overflow at entry
			for (int p = 0; p < NPAIR; p++) begin
				if (k == ST_DV0) r.sat[p] = (e.drem[p] >= e.root);
				c2 = {e.drem[p], e.dlow[p][47]};
				df = c2 - {1'b0, e.root};
				if (c2 >= {1'b0, e.root}) begin
					r.drem[p] = df[31:0];
					r.dq[p]   = {e.dq[p][46:0], 1'b1};
				end else begin
					r.drem[p] = c2[31:0];
					r.dq[p]   = {e.dq[p][46:0], 1'b0};
				end
				r.dlow[p] = {e.dlow[p][46:0], 1'b0};
			end
		end
		return r;
	endfunction

	function automatic logic [2:0] lowest(input logic [LOCAL_DOFS-1:0] m);
		logic [2:0] r;
		r = '0;
		for (int i = LOCAL_DOFS - 1; i >= 0; i--) if (m[i]) r = 3'(i);
		return r;
	endfunction

	function automatic logic [LOCAL_DOFS-1:0] upto(input logic [2:0] p);
		logic [LOCAL_DOFS-1:0] r;
		for (int i = 0; i < LOCAL_DOFS; i++) r[i] = (3'(i) <= p);
		return r;
	endfunction

	function automatic logic [1:0] loc(input logic [2:0] d);
		return (d >= 3'(DOFS_PER_NODE)) ? 2'(d - 3'(DOFS_PER_NODE)) : d[1:0];
	endfunction

	function automatic logic [2:0] pair_of(input logic [1:0] i, input logic [1:0] j);
		logic [1:0] lo;
		logic [1:0] hi;
		logic [2:0] r;
		lo = (i < j) ? i : j;
		hi = (i < j) ? j : i;
		r  = '0;
		for (int p = 0; p < NPAIR; p++)
			if (PAIR_A[p] == lo && PAIR_B[p] == hi) r = 3'(p);
		return r;
	endfunction

	elem_t            pipe_s [NST];
	logic [NST-1:0]   pv_s;
	logic             adv;
	logic             take;

	logic                        bv_q;
	logic                        bzero_q;
	logic [2:0]                  ba_q;
	logic [2:0]                  bb_q;
	logic [LOCAL_DOFS-1:0]       bact_q;
	logic [LOCAL_DOFS-1:0][11:0] bidx_q;
	logic [2:0]                  bsgn_q;
	logic [NPAIR-1:0][47:0]      bmag_q;
	logic [NPAIR-1:0]            bsat_q;

	logic                        mv_q;
	logic [OUT_W-1:0]            mdata_q;
	logic                        muser_q;
	logic                        mlast_q;

	logic                  oready;
	logic                  emit;
	logic                  fin;
	logic [LOCAL_DOFS-1:0] rest_a;
	logic [LOCAL_DOFS-1:0] rest_b;
	logic [2:0]            na;
	logic [2:0]            nb;
	logic [1:0]            ia;
	logic [1:0]            ib;
	logic [2:0]            pi;
	logic [47:0]           mag;
	logic                  sat;
	logic                  neg;
	logic [47:0]           val;
	elem_t                 tail;

	// Stall everything when the last stage holds an element the buffer cannot take
	assign tail     = pipe_s[NST-1];
	assign adv      = !pv_s[NST-1] || take;
	assign s_tready = adv;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s <= '0;
		end else if (adv) begin
			pv_s <= {pv_s[NST-2:0], s_tvalid};
		end
	end

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_s[0] <= unpack(s_tdata);
		end
	end

	// Pipeline stages
	for (genvar k = 1; k < NST; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (adv) begin
				pipe_s[k] <= stage_fn(k, pipe_s[k-1]);
			end
		end
	end

	// Walk to the next free pair, row-major
	always_comb begin
		oready = !mv_q || m_tready;
		emit   = bv_q && oready;
		rest_b = bact_q & ~upto(bb_q);
		rest_a = bact_q & ~upto(ba_q);
		fin    = bzero_q || (rest_b == '0 && rest_a == '0);
		na     = (rest_b != '0) ? ba_q : lowest(rest_a);
		nb     = (rest_b != '0) ? lowest(rest_b) : lowest(bact_q);
		take   = pv_s[NST-1] && (!bv_q || (emit && fin));
	end

	// Sign and saturate the selected magnitude
	always_comb begin
		ia  = loc(ba_q);
		ib  = loc(bb_q);
		pi  = pair_of(ia, ib);
		mag = bmag_q[pi];
		sat = bsat_q[pi];
		neg = bsgn_q[ia] ^ bsgn_q[ib]
			^ ((ba_q >= 3'(DOFS_PER_NODE)) != (bb_q >= 3'(DOFS_PER_NODE)));
		if (!sat && mag == '0) begin
			val = '0;
		end else if (neg) begin
			val = (sat || mag > NEG_LIM) ? NEG_LIM : 48'd0 - mag;
		end else begin
			val = (sat || mag[47]) ? POS_LIM : mag;
		end
	end

	// Emit buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_q <= 1'b0;
			ba_q <= '0;
			bb_q <= '0;
		end else if (take) begin
			bv_q <= tail.zero || (tail.act != '0);
			ba_q <= lowest(tail.act);
			bb_q <= lowest(tail.act);
		end else if (emit && fin) begin
			bv_q <= 1'b0;
		end else if (emit) begin
			ba_q <= na;
			bb_q <= nb;
		end
	end

	// Emit buffer payload
	always_ff @(posedge clk) begin
		if (take) begin
			bzero_q <= tail.zero;
			bact_q  <= tail.act;
			bidx_q  <= tail.idx;
			bsgn_q  <= tail.sgn;
			bmag_q  <= tail.dq;
			bsat_q  <= tail.sat;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
		end else if (oready) begin
			mv_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (bzero_q) begin
				mdata_q <= '0;
			end else begin
				mdata_q <= {val, bidx_q[bb_q], bidx_q[ba_q]};
			end
			muser_q <= bzero_q;
			mlast_q <= fin;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = mdata_q;
	assign m_tuser  = muser_q;
	assign m_tlast  = mlast_q;

endmodule

`default_nettype wire

### tb/truss_element_stiffness_scatter_top_tb.sv
// ----------------------------------------------------------------------------
// Truss element stiffness scatter testbench
// Drives element beats with random idling and a long result-side hold-off,
// predicts every stiffness contribution in fixed point and checks each
// result beat in order against the predicted queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module truss_element_stiffness_scatter_top_tb;
	import tess_pkg::*;

	typedef struct packed {
		logic [11:0] row;
		logic [11:0] col;
		logic [47:0] val;
		logic        zero;
		logic        last;
	} contrib_t;

	localparam int WATCHDOG_LIMIT = 20000;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;
	logic                m_tuser;
	logic                m_tlast;

	contrib_t            contrib_q[$];
	int                  mismatch_count;
	int                  element_count;
	int                  result_count;
	int                  send_idle_pct;
	int                  recv_idle_pct;
	int                  hold_cycles;
	int                  quiet_cycles;

	truss_element_stiffness_scatter_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// Integer square root, floor
	function automatic logic [63:0] isqrt(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bitv;
		res  = 0;
		bitv = 64'h1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x   = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Predict every contribution of one element and queue it
	task automatic predict_element(input logic [31:0] dlt [3], input logic [31:0] ea,
			input logic [11:0] idx [6], input logic [5:0] mask);
		logic [63:0]  dm [3];
		logic [63:0]  cosm [3];
		logic         act [6];
		logic [63:0]  s, len, cc, q, r, mag;
		logic [127:0] prod;
		logic         neg;
		contrib_t     c;
		int           first, n;
		s = 0;
		for (int k = 0; k < 3; k++) begin
			dm[k] = dlt[k][31] ? 64'(-$signed({32'hFFFF_FFFF, dlt[k]})) : 64'(dlt[k]);
			s = s + dm[k] * dm[k];
		end
		for (int k = 0; k < 6; k++) act[k] = mask[k] && (idx[k] < MAX_DOFS);
		if (s == 0) begin
			c = '{row: 0, col: 0, val: 0, zero: 1'b1, last: 1'b1};
			contrib_q.push_back(c);
			return;
		end
		len = isqrt(s);
		for (int k = 0; k < 3; k++) cosm[k] = (dm[k] << 30) / len;
		first = contrib_q.size();
		n = 0;
		for (int a = 0; a < 6; a++) begin
			if (!act[a]) continue;
			for (int b = 0; b < 6; b++) begin
				if (!act[b]) continue;
				cc   = (cosm[a%3] * cosm[b%3]) >> 30;
				prod = 128'(ea) * 128'(cc);
				q    = 64'(prod / len);
				r    = 64'(prod % len);
				neg  = dlt[a%3][31] != dlt[b%3][31];
				if ((a < 3) != (b < 3)) neg = !neg;
				if (q > (64'h1 << 46)) mag = (64'h1 << 47) + 1;
				else mag = 4 * q + (4 * r) / len;
				c.row = idx[a]; c.col = idx[b]; c.zero = 1'b0; c.last = 1'b0;
				if (mag == 0) c.val = 0;
				else if (neg) begin
					if (mag > (64'h1 << 47)) mag = 64'h1 << 47;
					c.val = 48'(-mag);
				end else begin
					if (mag > (64'h1 << 47) - 1) mag = (64'h1 << 47) - 1;
					c.val = 48'(mag);
				end
				contrib_q.push_back(c);
				n++;
			end
		end
		if (n > 0) contrib_q[first + n - 1].last = 1'b1;
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h, want %h", what, got, want);
		mismatch_count++;
	endtask

	// Send one element beat, idling first as the sender profile says
	task automatic send_element(input logic [31:0] dlt [3], input logic [31:0] ea,
			input logic [11:0] idx [6], input logic [5:0] mask);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata  <= {2'b0, mask, idx[5], idx[4], idx[3], idx[2], idx[1], idx[0],
			ea, dlt[2], dlt[1], dlt[0]};
		s_tvalid <= 1'b1;
		predict_element(dlt, ea, idx, mask);
		element_count++;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_delta(input int mode);
		case (mode)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
			2: return 32'h0;
			default: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
		endcase
	endfunction

	task automatic send_random(input int count);
		logic [31:0] dlt [3];
		logic [11:0] idx [6];
		logic [31:0] ea;
		logic [5:0]  mask;
		for (int i = 0; i < count; i++) begin
			for (int k = 0; k < 3; k++) dlt[k] = rand_delta($urandom_range(3));
			if ($urandom_range(19) == 0) dlt = '{0, 0, 0};
			ea = $urandom_range(1) ? $urandom() : $urandom_range(0, 1 << 20);
			for (int k = 0; k < 6; k++) idx[k] = 12'($urandom());
			// Mostly small masks keep the run short
			mask = $urandom_range(3) == 0 ? 6'($urandom()) : 6'(1 << $urandom_range(5))
				| 6'(1 << $urandom_range(5));
			send_element(dlt, ea, idx, mask);
		end
	endtask

	// Wait until every queued contribution has arrived, then let the pipe drain
	task automatic drain();
		s_tvalid <= 1'b0;
		while (contrib_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_directed();
		logic [31:0] dlt [3];
		logic [11:0] idx [6];
		idx = '{12'd0, 12'd1, 12'd2, 12'd4093, 12'd4094, 12'd4095};
		// Axis-aligned, all free
		dlt = '{32'h0001_0000, 0, 0};
		send_element(dlt, 32'd1000, idx, 6'h3F);
		// Zero length
		dlt = '{0, 0, 0};
		send_element(dlt, 32'hFFFF_FFFF, idx, 6'h3F);
		// No free dofs
		dlt = '{32'h0003_0000, 32'hFFFC_0000, 0};
		send_element(dlt, 32'd5, idx, 6'h00);
		// Extreme deltas, saturating rigidity
		dlt = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		send_element(dlt, 32'hFFFF_FFFF, idx, 6'h3F);
		dlt = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001};
		send_element(dlt, 32'hFFFF_FFFF, idx, 6'h2D);
		// Tiny length saturates
		dlt = '{32'h0000_0001, 0, 0};
		send_element(dlt, 32'hFFFF_FFFF, idx, 6'h09);
		dlt = '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF};
		send_element(dlt, 32'd0, idx, 6'h3F);
		dlt = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
		send_element(dlt, 32'd1, idx, 6'h12);
		drain();
	endtask

	// Hold results off long enough that the pipeline backs up into the input,
	// then keep offering elements against the stalled input
	task automatic test_backpressure();
		hold_cycles = 400;
		send_random(2);
		s_tvalid <= 1'b0;
		repeat (150) @(negedge clk);
		send_random(18);
		drain();
	endtask

	task automatic test_random(input int s_pct, input int r_pct, input int count);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		send_random(count);
		drain();
	endtask

	// Result side: stall at random and compare each beat with the oldest prediction
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	always @(posedge clk) begin
		contrib_t want;
		if (arst_n && m_tvalid && m_tready) begin
			result_count++;
			if (contrib_q.size() == 0) begin
				report_mismatch("unexpected beat", 64'(m_tdata), 0);
			end else begin
				want = contrib_q.pop_front();
				if (m_tdata[11:0] !== want.row)
					report_mismatch("row_index", 64'(m_tdata[11:0]), 64'(want.row));
				if (m_tdata[23:12] !== want.col)
					report_mismatch("column_index", 64'(m_tdata[23:12]), 64'(want.col));
				if (m_tdata[71:24] !== want.val)
					report_mismatch("contribution", 64'(m_tdata[71:24]), 64'(want.val));
				if (m_tuser !== want.zero)
					report_mismatch("zero_length", 64'(m_tuser), 64'(want.zero));
				if (m_tlast !== want.last)
					report_mismatch("last_of_element", 64'(m_tlast), 64'(want.last));
			end
		end
	end

	// Watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		arst_n         = 1'b0;
		mismatch_count = 0;
		element_count  = 0;
		result_count   = 0;
		send_idle_pct  = 0;
		recv_idle_pct  = 0;
		hold_cycles    = 0;
		quiet_cycles   = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_random(29, 56, 35);
		test_random(56, 29, 35);
		test_random(0, 0, 35);
		$display("covered %0d elements and %0d contribution beats, incl. zero-length,",
			element_count, result_count);
		$display("empty masks, saturation and a long result-side stall");
		if (mismatch_count == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule

### sim.f
sv/tess_pkg.sv
sv/truss_element_stiffness_scatter_top.sv
tb/truss_element_stiffness_scatter_top_tb.sv
